### rtl/kvt_pkg.sv
// shared types and codes for the key/value table engine
`timescale 1ns / 1ps

package kvt_pkg;

    // request operation codes
    localparam logic [2:0] CMD_SELECT   = 3'd0;
    localparam logic [2:0] CMD_COUNT    = 3'd1;
    localparam logic [2:0] CMD_INSERT   = 3'd2;
    localparam logic [2:0] CMD_UPDATE   = 3'd3;
    localparam logic [2:0] CMD_DELETE   = 3'd4;
    localparam logic [2:0] CMD_SHUTDOWN = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    typedef enum logic [1:0] {
        PSEL_ZERO,
        PSEL_NEW,
        PSEL_RAM
    } psel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_PL_RD,
        S_DEL_RD,
        S_DEL_SHIFT,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       search_step;
        logic       wr_insert;
        logic       wr_update;
        logic       pl_rd;
        logic       shift_start;
        logic       shift_step;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       load_out;
        logic [2:0] res_status;
        logic       res_ok;
        psel_t      res_psel;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       hit;
        logic       miss;
        logic       full;
        logic       shift_first;
        logic       shift_more;
        logic       out_free;
    } dp_stat_t;

endpackage

### rtl/kvt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/kvt_ctrl.sv
// request sequencer for the key/value table engine
`timescale 1ns / 1ps

module kvt_ctrl
    import kvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output ctl_cmd_t ctl
);

    state_t     state_reg, state_next;
    logic [2:0] res_status_reg, res_status_next;
    logic       res_ok_reg, res_ok_next;
    psel_t      res_psel_reg, res_psel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_OK;
            res_ok_reg     <= 1'b0;
            res_psel_reg   <= PSEL_ZERO;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_ok_reg     <= res_ok_next;
            res_psel_reg   <= res_psel_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_ok_next     = res_ok_reg;
        res_psel_next   = res_psel_reg;
        ctl             = '0;
        ctl.res_status  = res_status_reg;
        ctl.res_ok      = res_ok_reg;
        ctl.res_psel    = res_psel_reg;
        in_stall        = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_status_next = ST_OK;
                res_ok_next     = 1'b1;
                res_psel_next   = PSEL_ZERO;
                case (stat.op)
                    CMD_SELECT, CMD_INSERT, CMD_UPDATE, CMD_DELETE:
                    begin
                        state_next = S_SEARCH;
                    end
                    CMD_COUNT, CMD_SHUTDOWN:
                    begin
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        res_status_next = ST_UNKNOWN;
                        res_ok_next     = 1'b0;
                        state_next      = S_DONE;
                    end
                endcase
            end

            S_SEARCH:
            begin
                ctl.search_step = 1'b1;
                if (stat.hit)
                begin
                    case (stat.op)
                        CMD_SELECT:
                        begin
                            state_next = S_PL_RD;
                        end
                        CMD_INSERT:
                        begin
                            res_status_next = ST_EXISTS;
                            res_ok_next     = 1'b0;
                            state_next      = S_DONE;
                        end
                        CMD_UPDATE:
                        begin
                            ctl.wr_update = 1'b1;
                            res_psel_next = PSEL_NEW;
                            state_next    = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DEL_RD;
                        end
                    endcase
                end
                else if (stat.miss)
                begin
                    state_next = S_DONE;
                    if (stat.op != CMD_INSERT)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_ok_next     = 1'b0;
                    end
                    else if (stat.full)
                    begin
                        res_status_next = ST_FULL;
                        res_ok_next     = 1'b0;
                    end
                    else
                    begin
                        ctl.wr_insert = 1'b1;
                        ctl.cnt_inc   = 1'b1;
                        res_psel_next = PSEL_NEW;
                    end
                end
            end

            S_PL_RD:
            begin
                ctl.pl_rd     = 1'b1;
                res_psel_next = PSEL_RAM;
                state_next    = S_DONE;
            end

            S_DEL_RD:
            begin
                if (stat.shift_first)
                begin
                    ctl.shift_start = 1'b1;
                    state_next      = S_DEL_SHIFT;
                end
                else
                begin
                    ctl.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end

            S_DEL_SHIFT:
            begin
                ctl.shift_step = 1'b1;
                if (!stat.shift_more)
                begin
                    ctl.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/kvt_dp.sv
// request registers, key scan, entry shifter and result register
`timescale 1ns / 1ps

module kvt_dp
    import kvt_pkg::*;
#(
    parameter int TABLE_DEPTH  = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ctl_cmd_t                            ctl,
    output dp_stat_t                            stat,
    input  logic [2:0]                          cmd,
    input  logic signed [31:0]                  key,
    input  logic [PAYLOAD_BITS-1:0]             payload,
    input  logic [7:0]                          requester_tag,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic                                success,
    output logic signed [31:0]                  key_echo,
    output logic [PAYLOAD_BITS-1:0]             payload_out,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    entry_total,
    output logic [7:0]                          tag_echo
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // request
    logic [2:0]              op_reg;
    logic [31:0]             key_reg;
    logic [PAYLOAD_BITS-1:0] pl_reg;
    logic [7:0]              tag_reg;

    // scan and shift control
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]    sh_ptr_reg, sh_ptr_next;
    logic             out_valid_reg, out_valid_next;

    // result
    logic [2:0]              status_reg;
    logic                    success_reg;
    logic [31:0]             key_echo_reg;
    logic [PAYLOAD_BITS-1:0] pout_reg;
    logic [CNT_W-1:0]        total_reg;
    logic [7:0]              tag_echo_reg;

    logic [31:0]             key_rdata;
    logic [PAYLOAD_BITS-1:0] pl_rdata;
    logic                    hit, issue, sh_rd;
    logic [CNT_W:0]          pos_plus1, sh_plus2;
    logic                    key_re, pl_re, key_we, pl_we;
    logic [AW-1:0]           raddr, waddr;
    logic [31:0]             key_wdata;
    logic [PAYLOAD_BITS-1:0] pl_wdata;
    logic [PAYLOAD_BITS-1:0] pout_sel;

    assign hit       = cmp_vld_reg && (key_rdata == key_reg);
    assign issue     = ctl.search_step && !hit && (rd_ptr_reg < count_reg);
    assign pos_plus1 = {{(CNT_W + 1 - AW){1'b0}}, cmp_idx_reg} + (CNT_W + 1)'(1);
    assign sh_plus2  = {{(CNT_W + 1 - AW){1'b0}}, sh_ptr_reg} + (CNT_W + 1)'(2);
    assign sh_rd     = ctl.shift_step && (sh_plus2 < {1'b0, count_reg});

    assign stat.op          = op_reg;
    assign stat.hit         = hit;
    assign stat.miss        = !cmp_vld_reg && (rd_ptr_reg >= count_reg);
    assign stat.full        = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.shift_first = (pos_plus1 < {1'b0, count_reg});
    assign stat.shift_more  = (sh_plus2 < {1'b0, count_reg});
    assign stat.out_free    = !out_valid_reg || !out_stall;

    // shared read address for both stores
    always_comb
    begin
        if (ctl.shift_start)
        begin
            raddr = pos_plus1[AW-1:0];
        end
        else if (ctl.shift_step)
        begin
            raddr = sh_plus2[AW-1:0];
        end
        else if (ctl.pl_rd)
        begin
            raddr = cmp_idx_reg;
        end
        else
        begin
            raddr = rd_ptr_reg[AW-1:0];
        end
    end

    assign key_re = issue || ctl.shift_start || sh_rd;
    assign pl_re  = ctl.pl_rd || ctl.shift_start || sh_rd;

    always_comb
    begin
        if (ctl.wr_insert)
        begin
            waddr = count_reg[AW-1:0];
        end
        else if (ctl.wr_update)
        begin
            waddr = cmp_idx_reg;
        end
        else
        begin
            waddr = sh_ptr_reg;
        end
    end

    assign key_we    = ctl.wr_insert || ctl.shift_step;
    assign pl_we     = ctl.wr_insert || ctl.wr_update || ctl.shift_step;
    assign key_wdata = ctl.shift_step ? key_rdata : key_reg;
    assign pl_wdata  = ctl.shift_step ? pl_rdata : pl_reg;

    kvt_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    kvt_ram #(
        .WIDTH(PAYLOAD_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_pl_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (waddr),
        .wdata (pl_wdata),
        .re    (pl_re),
        .raddr (raddr),
        .rdata (pl_rdata)
    );

    always_comb
    begin
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        sh_ptr_next    = sh_ptr_reg;
        out_valid_next = out_valid_reg;

        if (ctl.accept)
        begin
            rd_ptr_next  = '0;
            cmp_vld_next = 1'b0;
        end
        // compare stage lags the read pointer by one entry; freeze on a hit
        if (ctl.search_step && !hit)
        begin
            cmp_vld_next = issue;
            cmp_idx_next = rd_ptr_reg[AW-1:0];
            if (issue)
            begin
                rd_ptr_next = rd_ptr_reg + CNT_W'(1);
            end
        end
        if (ctl.shift_start)
        begin
            sh_ptr_next = cmp_idx_reg;
        end
        else if (sh_rd)
        begin
            sh_ptr_next = sh_ptr_reg + AW'(1);
        end
        if (ctl.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            sh_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            sh_ptr_reg    <= sh_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        case (ctl.res_psel)
            PSEL_NEW: pout_sel = pl_reg;
            PSEL_RAM: pout_sel = pl_rdata;
            default:  pout_sel = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            op_reg  <= cmd;
            key_reg <= key;
            pl_reg  <= payload;
            tag_reg <= requester_tag;
        end
        if (ctl.load_out)
        begin
            status_reg   <= ctl.res_status;
            success_reg  <= ctl.res_ok;
            key_echo_reg <= key_reg;
            pout_reg     <= pout_sel;
            total_reg    <= count_reg;
            tag_echo_reg <= tag_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign success     = success_reg;
    assign key_echo    = key_echo_reg;
    assign payload_out = pout_reg;
    assign entry_total = total_reg;
    assign tag_echo    = tag_echo_reg;

endmodule

### rtl/key_value_table_engine.sv
// Packed table of unique 32-bit keys with a payload word per key. Requests run one at a time.
// Count, shutdown and unknown codes skip the key scan; select, insert, update and delete
// scan the key memory one entry per cycle, and the scan stops early when the key is found.
// A select that hits then reads the payload store. A delete that hits spends the rest of
// the scan closing the gap, one later entry per cycle. Each store has a single read port,
// walked one entry a cycle. A new request is taken as soon as the previous one has been
// placed in the result register, even if that result is still stalled. Stores need no
// clearing after reset.
`timescale 1ns / 1ps

module key_value_table_engine
    import kvt_pkg::*;
#(
    parameter int TABLE_DEPTH  = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          cmd,
    input  logic signed [31:0]                  key,
    input  logic [PAYLOAD_BITS-1:0]             payload,
    input  logic [7:0]                          requester_tag,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic                                success,
    output logic signed [31:0]                  key_echo,
    output logic [PAYLOAD_BITS-1:0]             payload_out,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    entry_total,
    output logic [7:0]                          tag_echo
);

    ctl_cmd_t ctl;
    dp_stat_t stat;

    kvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    kvt_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (cmd),
        .key           (key),
        .payload       (payload),
        .requester_tag (requester_tag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .success       (success),
        .key_echo      (key_echo),
        .payload_out   (payload_out),
        .entry_total   (entry_total),
        .tag_echo      (tag_echo)
    );

endmodule
